// File: hw/rtl/slsd_pkg.sv
// shared types and constants for the sorted list block
package slsd_pkg;

    localparam int DEF_LIST_DEPTH = 16;
    localparam int VALUE_W        = 32;
    localparam int MODE_W         = 2;
    localparam int COUNT_OUT_W    = 5;

    // request operation codes (code three is unused and does nothing)
    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_SEARCH = 2'd1,
        MODE_DELETE = 2'd2
    } slsd_mode_t;

    // sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } slsd_state_t;

    // one request
    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;
    } slsd_req_t;

    // one result
    typedef struct packed {
        logic                   found;
        logic                   full_refused;
        logic [COUNT_OUT_W-1:0] entry_count;
    } slsd_rsp_t;

    // controls broadcast from the sequencer to every cell
    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic del_en;
    } slsd_ctrl_t;

endpackage

// File: hw/rtl/slsd_cell.sv
// one slot of the sorted list: holds an entry, compares it and shifts with its neighbors
module slsd_cell (
    input  logic                                clk,
    input  logic                                occupied,
    input  slsd_pkg::slsd_ctrl_t                ctrl,
    input  logic signed [slsd_pkg::VALUE_W-1:0] cmp_value,
    input  logic signed [slsd_pkg::VALUE_W-1:0] new_value,
    input  logic                                lt_left,
    input  logic signed [slsd_pkg::VALUE_W-1:0] left_entry,
    input  logic signed [slsd_pkg::VALUE_W-1:0] right_entry,
    output logic signed [slsd_pkg::VALUE_W-1:0] entry,
    output logic                                lt,
    output logic                                eq
);

    logic signed [slsd_pkg::VALUE_W-1:0] entry_reg;
    logic                                lt_reg;
    logic                                eq_reg;
    logic                                lt_next;
    logic                                eq_next;

    // compare held entry against the incoming request value
    always_comb
    begin
        lt_next = occupied && (entry_reg < cmp_value);
        eq_next = occupied && (entry_reg == cmp_value);
    end

    // flags captured when a request is taken
    always_ff @(posedge clk)
    begin
        if (ctrl.cmp_en)
        begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
    end

    // entry update: insert opens a gap at the first entry not below the value,
    // delete closes over the first equal entry; lower cells keep their entry
    always_ff @(posedge clk)
    begin
        if (ctrl.ins_en && !lt_reg)
        begin
            entry_reg <= lt_left ? new_value : left_entry;
        end
        else if (ctrl.del_en && !lt_reg)
        begin
            entry_reg <= right_entry;
        end
    end

    assign entry = entry_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

// File: hw/rtl/sorted_list_insert_search_delete.sv
// sorted list top level: request sequencer, entry count and the row of cells
//
//  channel   signals                    direction  flow control
//  request   start, busy, req           in         taken when start && !busy
//  result    done, result               out        one-cycle strobe, no stall
//
// a request passes through the apply state: the edge that takes it captures the compare
// flags of every cell, the next edge shifts the row and registers the result.
// done is high in the cycle after that, and busy is already low there, so a
// new request can go in while done is high. every cell compares in parallel.
// reset clears the count and the sequencer; slots are not cleared and only
// slots below the count are ever used. the result side has no back-pressure.
module sorted_list_insert_search_delete #(
    parameter int LIST_DEPTH = slsd_pkg::DEF_LIST_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  slsd_pkg::slsd_req_t req,
    output logic                done,
    output slsd_pkg::slsd_rsp_t result
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    slsd_pkg::slsd_state_t state_reg;
    slsd_pkg::slsd_state_t state_next;
    slsd_pkg::slsd_req_t   req_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  done_reg;
    slsd_pkg::slsd_rsp_t   rsp_reg;
    slsd_pkg::slsd_rsp_t   rsp_next;
    slsd_pkg::slsd_ctrl_t  ctrl;
    logic                  take;
    logic                  applying;
    logic                  list_full;
    logic                  any_eq;
    logic                  is_insert;
    logic                  is_search;
    logic                  is_delete;
    logic [31:0]           count_wide;

    logic signed [slsd_pkg::VALUE_W-1:0] entry_vec [LIST_DEPTH];
    logic [LIST_DEPTH-1:0]               lt_vec;
    logic [LIST_DEPTH-1:0]               eq_vec;
    logic [LIST_DEPTH-1:0]               occ_vec;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            slsd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = slsd_pkg::ST_APPLY;
                end
            end
            slsd_pkg::ST_APPLY:
            begin
                state_next = slsd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = slsd_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        busy     = 1'b0;
        applying = 1'b0;
        unique case (state_reg)
            slsd_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                applying = 1'b0;
            end
            slsd_pkg::ST_APPLY:
            begin
                busy     = 1'b1;
                applying = 1'b1;
            end
            default:
            begin
                busy     = 1'b0;
                applying = 1'b0;
            end
        endcase
    end

    assign take = start && !busy;

    // request decode
    always_comb
    begin
        is_insert = req_reg.mode == slsd_pkg::MODE_INSERT;
        is_search = req_reg.mode == slsd_pkg::MODE_SEARCH;
        is_delete = req_reg.mode == slsd_pkg::MODE_DELETE;
    end

    assign list_full = count_reg == CNT_W'(LIST_DEPTH);
    assign any_eq    = |eq_vec;

    // cell controls
    always_comb
    begin
        ctrl.cmp_en = take;
        ctrl.ins_en = applying && is_insert && !list_full;
        ctrl.del_en = applying && is_delete && any_eq;
    end

    // count update
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.del_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // result fields
    always_comb
    begin
        count_wide            = 32'(count_next);
        rsp_next.found        = (is_search || is_delete) && any_eq;
        rsp_next.full_refused = is_insert && list_full;
        rsp_next.entry_count  = count_wide[slsd_pkg::COUNT_OUT_W-1:0];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= slsd_pkg::ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= applying;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg <= req;
        end
        if (applying)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done   = done_reg;
    assign result = rsp_reg;

    // row of cells
    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        logic                                lt_left_w;
        logic signed [slsd_pkg::VALUE_W-1:0] left_w;
        logic signed [slsd_pkg::VALUE_W-1:0] right_w;

        assign occ_vec[i] = count_reg > CNT_W'(i);

        if (i == 0)
        begin : g_first
            assign lt_left_w = 1'b1;
            assign left_w    = entry_vec[i];
        end
        else
        begin : g_mid
            assign lt_left_w = lt_vec[i-1];
            assign left_w    = entry_vec[i-1];
        end

        if (i == LIST_DEPTH - 1)
        begin : g_last
            assign right_w = entry_vec[i];
        end
        else
        begin : g_inner
            assign right_w = entry_vec[i+1];
        end

        slsd_cell u_cell (
            .clk        (clk),
            .occupied   (occ_vec[i]),
            .ctrl       (ctrl),
            .cmp_value  (req.value),
            .new_value  (req_reg.value),
            .lt_left    (lt_left_w),
            .left_entry (left_w),
            .right_entry(right_w),
            .entry      (entry_vec[i]),
            .lt         (lt_vec[i]),
            .eq         (eq_vec[i])
        );
    end

    // a result strobe always follows an apply cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(applying))
        else $error("result strobe without an apply cycle");

    // the count never runs past the number of slots
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("entry count beyond list depth");

    // a refused insert leaves a full list and reports it
    assert property (@(posedge clk) disable iff (!rst_n)
        done && result.full_refused |-> list_full && $stable(count_reg))
        else $error("insert refused on a list that is not full");

    // busy only for the single apply cycle after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        take |=> busy ##1 !busy)
        else $error("request did not finish in two cycles");

endmodule
